FILE: design/plsf_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and the solve microprogram for the parabola fit.
// Used by plsf_ctrl, plsf_dpath and parabola_least_squares_fit.
package plsf_pkg;

  localparam int unsigned X_W    = 12;
  localparam int unsigned Y_W    = 16;
  localparam int unsigned CNT_W  = 11;
  localparam int unsigned COEF_W = 32;
  localparam int unsigned WIDE   = 256;
  localparam int unsigned RF_AW  = 4;
  localparam int unsigned PC_W   = 6;
  localparam int unsigned STEP_W = 6;
  localparam int unsigned QUO_W  = 33;
  localparam int unsigned MIN_POINTS = 3;

  localparam logic [1:0] KIND_ADD = 2'd0;
  localparam logic [1:0] KIND_REM = 2'd1;
  localparam logic [1:0] KIND_CLR = 2'd2;

  localparam logic [2:0] LD_LAST = 3'd7;
  localparam logic [STEP_W-1:0] DIV_LAST = STEP_W'(QUO_W - 1);

  localparam logic [RF_AW-1:0] RF_N  = 4'd0;
  localparam logic [RF_AW-1:0] RF_S1 = 4'd1;
  localparam logic [RF_AW-1:0] RF_S2 = 4'd2;
  localparam logic [RF_AW-1:0] RF_S3 = 4'd3;
  localparam logic [RF_AW-1:0] RF_S4 = 4'd4;
  localparam logic [RF_AW-1:0] RF_T0 = 4'd5;
  localparam logic [RF_AW-1:0] RF_T1 = 4'd6;
  localparam logic [RF_AW-1:0] RF_T2 = 4'd7;
  localparam logic [RF_AW-1:0] RF_P  = 4'd8;
  localparam logic [RF_AW-1:0] RF_Q  = 4'd9;
  localparam logic [RF_AW-1:0] RF_A  = 4'd10;
  localparam logic [RF_AW-1:0] RF_B  = 4'd11;
  localparam logic [RF_AW-1:0] RF_C  = 4'd12;
  localparam logic [RF_AW-1:0] RF_E  = 4'd13;
  localparam logic [RF_AW-1:0] RF_F  = 4'd14;
  localparam logic [RF_AW-1:0] RF_NN = 4'd15;
  localparam logic [RF_AW-1:0] RF_Z  = RF_C;
  localparam logic [RF_AW-1:0] RF_BN = RF_F;
  localparam logic [RF_AW-1:0] RF_BD = RF_A;
  localparam logic [RF_AW-1:0] RF_CN = RF_B;
  localparam logic [RF_AW-1:0] RF_D3 = RF_E;

  localparam logic [RF_AW-1:0] COEF_A = 4'd0;
  localparam logic [RF_AW-1:0] COEF_B = 4'd1;
  localparam logic [RF_AW-1:0] COEF_C = 4'd2;

  typedef enum logic [2:0] {
    UOP_MUL,
    UOP_SUB,
    UOP_TEST,
    UOP_DIV,
    UOP_END
  } uop_e;

  typedef struct packed {
    uop_e              op;
    logic [RF_AW-1:0]  dst;
    logic [RF_AW-1:0]  sa;
    logic [RF_AW-1:0]  sb;
    logic [STEP_W-1:0] k;
  } uop_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ACC1,
    ST_ACC2,
    ST_ACC3,
    ST_LOAD,
    ST_PREP,
    ST_READ,
    ST_EXEC,
    ST_MUL,
    ST_MULW,
    ST_DSCALE,
    ST_DSTEP,
    ST_DSTORE,
    ST_FIN
  } ctl_state_e;

  typedef struct packed {
    logic [1:0]               kind;
    logic signed [X_W-1:0]    x;
    logic signed [Y_W-1:0]    y;
  } in_t;

  typedef struct packed {
    logic                     fit_valid;
    logic signed [COEF_W-1:0] coef_a;
    logic signed [COEF_W-1:0] coef_b;
    logic signed [COEF_W-1:0] coef_c;
    logic [CNT_W-1:0]         points_held;
  } out_t;

  typedef struct packed {
    logic             capture;
    logic             upd;
    logic             ld;
    logic [2:0]       ld_idx;
    logic             rd;
    logic [RF_AW-1:0] sa;
    logic [RF_AW-1:0] sb;
    logic [RF_AW-1:0] dst;
    logic             mul_load;
    logic             mul_step;
    logic             mul_last;
    logic             wr_acc;
    logic             wr_sub;
    logic             div_abs;
    logic             div_scale;
    logic             div_step;
    logic             div_store;
    logic             fit_clr;
    logic             fit_set;
    logic             out_load;
  } cmd_t;

  typedef struct packed {
    logic n_ok;
    logic zero;
  } sts_t;

  // serial operand is sb; k covers its signed width
  function automatic uop_t uop_at(input logic [PC_W-1:0] pc);
    uop_t u;
    u = '{UOP_END, RF_N, RF_N, RF_N, 6'd0};
    case (pc)
      6'd0:  u = '{UOP_MUL,  RF_P,  RF_S3, RF_N,  6'd12};
      6'd1:  u = '{UOP_MUL,  RF_Q,  RF_S2, RF_S1, 6'd23};
      6'd2:  u = '{UOP_SUB,  RF_A,  RF_P,  RF_Q,  6'd0};
      6'd3:  u = '{UOP_MUL,  RF_P,  RF_S2, RF_N,  6'd12};
      6'd4:  u = '{UOP_MUL,  RF_Q,  RF_S1, RF_S1, 6'd23};
      6'd5:  u = '{UOP_SUB,  RF_B,  RF_P,  RF_Q,  6'd0};
      6'd6:  u = '{UOP_MUL,  RF_P,  RF_S4, RF_N,  6'd12};
      6'd7:  u = '{UOP_MUL,  RF_Q,  RF_S2, RF_S2, 6'd33};
      6'd8:  u = '{UOP_SUB,  RF_C,  RF_P,  RF_Q,  6'd0};
      6'd9:  u = '{UOP_MUL,  RF_P,  RF_T1, RF_N,  6'd12};
      6'd10: u = '{UOP_MUL,  RF_Q,  RF_T0, RF_S1, 6'd23};
      6'd11: u = '{UOP_SUB,  RF_E,  RF_P,  RF_Q,  6'd0};
      6'd12: u = '{UOP_MUL,  RF_P,  RF_T2, RF_N,  6'd12};
      6'd13: u = '{UOP_MUL,  RF_Q,  RF_S2, RF_T0, 6'd27};
      6'd14: u = '{UOP_SUB,  RF_F,  RF_P,  RF_Q,  6'd0};
      6'd15: u = '{UOP_MUL,  RF_P,  RF_C,  RF_B,  6'd47};
      6'd16: u = '{UOP_MUL,  RF_Q,  RF_A,  RF_A,  6'd57};
      6'd17: u = '{UOP_SUB,  RF_NN, RF_P,  RF_Q,  6'd0};
      6'd18: u = '{UOP_TEST, RF_N,  RF_B,  RF_NN, 6'd0};
      6'd19: u = '{UOP_MUL,  RF_P,  RF_F,  RF_B,  6'd47};
      6'd20: u = '{UOP_MUL,  RF_Q,  RF_A,  RF_E,  6'd51};
      6'd21: u = '{UOP_SUB,  RF_Z,  RF_P,  RF_Q,  6'd0};
      6'd22: u = '{UOP_MUL,  RF_P,  RF_NN, RF_E,  6'd51};
      6'd23: u = '{UOP_MUL,  RF_Q,  RF_Z,  RF_A,  6'd57};
      6'd24: u = '{UOP_SUB,  RF_BN, RF_P,  RF_Q,  6'd0};
      6'd25: u = '{UOP_MUL,  RF_BD, RF_NN, RF_B,  6'd47};
      6'd26: u = '{UOP_MUL,  RF_P,  RF_BD, RF_T0, 6'd27};
      6'd27: u = '{UOP_MUL,  RF_Q,  RF_Z,  RF_S2, 6'd33};
      6'd28: u = '{UOP_MUL,  RF_Q,  RF_Q,  RF_B,  6'd47};
      6'd29: u = '{UOP_SUB,  RF_P,  RF_P,  RF_Q,  6'd0};
      6'd30: u = '{UOP_MUL,  RF_Q,  RF_BN, RF_S1, 6'd23};
      6'd31: u = '{UOP_SUB,  RF_CN, RF_P,  RF_Q,  6'd0};
      6'd32: u = '{UOP_MUL,  RF_D3, RF_BD, RF_N,  6'd12};
      6'd33: u = '{UOP_DIV,  COEF_A, RF_Z,  RF_NN, 6'd0};
      6'd34: u = '{UOP_DIV,  COEF_B, RF_BN, RF_BD, 6'd0};
      6'd35: u = '{UOP_DIV,  COEF_C, RF_CN, RF_D3, 6'd0};
      default: u = '{UOP_END, RF_N, RF_N, RF_N, 6'd0};
    endcase
    return u;
  endfunction

endpackage

FILE: design/plsf_ctrl.sv
`timescale 1ns / 1ps
// Sequencer for the parabola fit: accumulate, load sums, run the solve program.
// Depends on plsf_pkg; drives plsf_dpath through cmd_t.
module plsf_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  input  plsf_pkg::sts_t   sts_i,
  output plsf_pkg::cmd_t   cmd_o
);

  plsf_pkg::ctl_state_e state_q, state_d;
  logic [plsf_pkg::PC_W-1:0]   pc_q, pc_d;
  logic [plsf_pkg::STEP_W-1:0] cnt_q, cnt_d;
  logic out_valid_q, out_valid_d;
  plsf_pkg::uop_t uop;
  logic mul_last;
  logic out_free;

  assign uop      = plsf_pkg::uop_at(pc_q);
  assign mul_last = (cnt_q == uop.k - 6'd1);
  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= plsf_pkg::ST_IDLE;
      pc_q        <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pc_q        <= pc_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    pc_d        = pc_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      plsf_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = plsf_pkg::ST_ACC1;
      end
      plsf_pkg::ST_ACC1: state_d = plsf_pkg::ST_ACC2;
      plsf_pkg::ST_ACC2: state_d = plsf_pkg::ST_ACC3;
      plsf_pkg::ST_ACC3: begin
        state_d = plsf_pkg::ST_LOAD;
        cnt_d   = '0;
      end
      plsf_pkg::ST_LOAD: begin
        cnt_d = cnt_q + 6'd1;
        if (cnt_q[2:0] == plsf_pkg::LD_LAST) state_d = plsf_pkg::ST_PREP;
      end
      plsf_pkg::ST_PREP: begin
        pc_d    = '0;
        state_d = sts_i.n_ok ? plsf_pkg::ST_READ : plsf_pkg::ST_FIN;
      end
      plsf_pkg::ST_READ: state_d = plsf_pkg::ST_EXEC;
      plsf_pkg::ST_EXEC: begin
        case (uop.op)
          plsf_pkg::UOP_MUL: begin
            cnt_d   = '0;
            state_d = plsf_pkg::ST_MUL;
          end
          plsf_pkg::UOP_SUB: begin
            pc_d    = pc_q + 6'd1;
            state_d = plsf_pkg::ST_READ;
          end
          plsf_pkg::UOP_TEST: begin
            pc_d    = pc_q + 6'd1;
            state_d = sts_i.zero ? plsf_pkg::ST_FIN : plsf_pkg::ST_READ;
          end
          plsf_pkg::UOP_DIV: state_d = plsf_pkg::ST_DSCALE;
          default:           state_d = plsf_pkg::ST_FIN;
        endcase
      end
      plsf_pkg::ST_MUL: begin
        cnt_d = cnt_q + 6'd1;
        if (mul_last) state_d = plsf_pkg::ST_MULW;
      end
      plsf_pkg::ST_MULW: begin
        pc_d    = pc_q + 6'd1;
        state_d = plsf_pkg::ST_READ;
      end
      plsf_pkg::ST_DSCALE: begin
        cnt_d   = '0;
        state_d = plsf_pkg::ST_DSTEP;
      end
      plsf_pkg::ST_DSTEP: begin
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == plsf_pkg::DIV_LAST) state_d = plsf_pkg::ST_DSTORE;
      end
      plsf_pkg::ST_DSTORE: begin
        pc_d    = pc_q + 6'd1;
        state_d = plsf_pkg::ST_READ;
      end
      plsf_pkg::ST_FIN: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          state_d     = plsf_pkg::ST_IDLE;
        end
      end
      default: state_d = plsf_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o        = '0;
    cmd_o.sa     = uop.sa;
    cmd_o.sb     = uop.sb;
    cmd_o.dst    = uop.dst;
    cmd_o.ld_idx = cnt_q[2:0];
    case (state_q)
      plsf_pkg::ST_IDLE:   cmd_o.capture = in_valid_i;
      plsf_pkg::ST_ACC3:   cmd_o.upd = 1'b1;
      plsf_pkg::ST_LOAD:   cmd_o.ld = 1'b1;
      plsf_pkg::ST_PREP:   cmd_o.fit_clr = 1'b1;
      plsf_pkg::ST_READ:   cmd_o.rd = 1'b1;
      plsf_pkg::ST_EXEC: begin
        case (uop.op)
          plsf_pkg::UOP_MUL: cmd_o.mul_load = 1'b1;
          plsf_pkg::UOP_SUB: cmd_o.wr_sub = 1'b1;
          plsf_pkg::UOP_DIV: cmd_o.div_abs = 1'b1;
          plsf_pkg::UOP_END: cmd_o.fit_set = 1'b1;
          default:           cmd_o.mul_load = 1'b0;
        endcase
      end
      plsf_pkg::ST_MUL: begin
        cmd_o.mul_step = 1'b1;
        cmd_o.mul_last = mul_last;
      end
      plsf_pkg::ST_MULW:   cmd_o.wr_acc = 1'b1;
      plsf_pkg::ST_DSCALE: cmd_o.div_scale = 1'b1;
      plsf_pkg::ST_DSTEP:  cmd_o.div_step = 1'b1;
      plsf_pkg::ST_DSTORE: cmd_o.div_store = 1'b1;
      plsf_pkg::ST_FIN:    cmd_o.out_load = out_free;
      default:             cmd_o.capture = 1'b0;
    endcase
  end

  assign in_stall_o  = (state_q != plsf_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

FILE: design/plsf_dpath.sv
`timescale 1ns / 1ps
// Datapath for the parabola fit: power sums, wide register file, serial
// multiplier, rounding divider and result register. Depends on plsf_pkg.
module plsf_dpath #(
  parameter int unsigned MAX_POINTS = 1024,
  parameter int unsigned X_BITS     = 12,
  parameter int unsigned Y_BITS     = 16,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  plsf_pkg::in_t  in_item_i,
  input  plsf_pkg::cmd_t cmd_i,
  output plsf_pkg::sts_t sts_o,
  output plsf_pkg::out_t out_item_o
);

  localparam int unsigned XS = plsf_pkg::X_W - X_BITS;
  localparam int unsigned YS = plsf_pkg::Y_W - Y_BITS;
  localparam int unsigned W  = plsf_pkg::WIDE;
  localparam int unsigned CW = plsf_pkg::COEF_W;

  logic [1:0]         kind_q;
  logic signed [11:0] x_q;
  logic signed [15:0] y_q;
  logic signed [23:0] x2_q;
  logic signed [27:0] xy_q;
  logic signed [35:0] x3_q;
  logic signed [47:0] x4_q;
  logic signed [39:0] x2y_q;

  logic [plsf_pkg::CNT_W-1:0] cnt_q;
  logic signed [22:0] sx_q;
  logic signed [32:0] sx2_q;
  logic signed [44:0] sx3_q;
  logic signed [54:0] sx4_q;
  logic signed [26:0] sy_q;
  logic signed [37:0] sxy_q;
  logic signed [48:0] sx2y_q;
  logic do_add, do_rem;

  logic [W-1:0] rf_mem [16];
  logic [W-1:0] rda_q, rdb_q;
  logic         wr_en;
  logic [plsf_pkg::RF_AW-1:0] wr_addr;
  logic [W-1:0] wr_data, ld_data;

  logic [W-1:0] aq_q, bq_q, acc_q, addend;
  logic [W-1:0] rem_q, dsh_q;
  logic [plsf_pkg::QUO_W-1:0] quo_q;
  logic         neg_q, ge;
  logic [CW-1:0] lim, mag, res;

  logic [CW-1:0] coef_q [3];
  logic          fit_q;
  plsf_pkg::out_t out_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      kind_q <= in_item_i.kind;
      x_q    <= $signed(in_item_i.x << XS) >>> XS;
      y_q    <= $signed(in_item_i.y << YS) >>> YS;
    end
    x2_q  <= x_q * x_q;
    xy_q  <= x_q * y_q;
    x3_q  <= x2_q * x_q;
    x4_q  <= x2_q * x2_q;
    x2y_q <= x2_q * y_q;
  end

  assign do_add = (kind_q == plsf_pkg::KIND_ADD) &&
                  (cnt_q < plsf_pkg::CNT_W'(MAX_POINTS));
  assign do_rem = (kind_q == plsf_pkg::KIND_REM) && (cnt_q != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      sx_q   <= '0;
      sx2_q  <= '0;
      sx3_q  <= '0;
      sx4_q  <= '0;
      sy_q   <= '0;
      sxy_q  <= '0;
      sx2y_q <= '0;
    end else if (cmd_i.upd) begin
      if (kind_q == plsf_pkg::KIND_CLR) begin
        cnt_q  <= '0;
        sx_q   <= '0;
        sx2_q  <= '0;
        sx3_q  <= '0;
        sx4_q  <= '0;
        sy_q   <= '0;
        sxy_q  <= '0;
        sx2y_q <= '0;
      end else if (do_add) begin
        cnt_q  <= cnt_q + 11'd1;
        sx_q   <= sx_q + 23'(x_q);
        sx2_q  <= sx2_q + 33'(x2_q);
        sx3_q  <= sx3_q + 45'(x3_q);
        sx4_q  <= sx4_q + 55'(x4_q);
        sy_q   <= sy_q + 27'(y_q);
        sxy_q  <= sxy_q + 38'(xy_q);
        sx2y_q <= sx2y_q + 49'(x2y_q);
      end else if (do_rem) begin
        cnt_q  <= cnt_q - 11'd1;
        sx_q   <= sx_q - 23'(x_q);
        sx2_q  <= sx2_q - 33'(x2_q);
        sx3_q  <= sx3_q - 45'(x3_q);
        sx4_q  <= sx4_q - 55'(x4_q);
        sy_q   <= sy_q - 27'(y_q);
        sxy_q  <= sxy_q - 38'(xy_q);
        sx2y_q <= sx2y_q - 49'(x2y_q);
      end
    end
  end

  always_comb begin
    case (cmd_i.ld_idx)
      3'd0:    ld_data = W'(cnt_q);
      3'd1:    ld_data = W'(sx_q);
      3'd2:    ld_data = W'(sx2_q);
      3'd3:    ld_data = W'(sx3_q);
      3'd4:    ld_data = W'(sx4_q);
      3'd5:    ld_data = W'(sy_q);
      3'd6:    ld_data = W'(sxy_q);
      default: ld_data = W'(sx2y_q);
    endcase
  end

  assign wr_en   = cmd_i.ld || cmd_i.wr_acc || cmd_i.wr_sub;
  assign wr_addr = cmd_i.ld ? {1'b0, cmd_i.ld_idx} : cmd_i.dst;
  assign wr_data = cmd_i.ld ? ld_data : (cmd_i.wr_acc ? acc_q : rda_q - rdb_q);

  always_ff @(posedge clk_i) begin
    if (wr_en) rf_mem[wr_addr] <= wr_data;
    if (cmd_i.rd) begin
      rda_q <= rf_mem[cmd_i.sa];
      rdb_q <= rf_mem[cmd_i.sb];
    end
  end

  assign addend = bq_q[0] ? aq_q : '0;
  assign ge     = (rem_q >= dsh_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_load) begin
      aq_q  <= rda_q;
      bq_q  <= rdb_q;
      acc_q <= '0;
    end else if (cmd_i.mul_step) begin
      aq_q  <= aq_q << 1;
      bq_q  <= bq_q >> 1;
      acc_q <= cmd_i.mul_last ? acc_q - addend : acc_q + addend;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_abs) begin
      neg_q <= rda_q[W-1] ^ rdb_q[W-1];
      rem_q <= rda_q[W-1] ? -rda_q : rda_q;
      dsh_q <= rdb_q[W-1] ? -rdb_q : rdb_q;
    end else if (cmd_i.div_scale) begin
      rem_q <= (rem_q << (FRAC_BITS + 1)) + dsh_q;
      dsh_q <= dsh_q << plsf_pkg::QUO_W;
      quo_q <= '0;
    end else if (cmd_i.div_step) begin
      if (ge) rem_q <= rem_q - dsh_q;
      dsh_q <= dsh_q >> 1;
      quo_q <= {quo_q[plsf_pkg::QUO_W-2:0], ge};
    end
  end

  always_comb begin
    lim = neg_q ? 32'h8000_0000 : 32'h7FFF_FFFF;
    mag = quo_q[CW-1:0];
    if (quo_q[plsf_pkg::QUO_W-1] || (mag > lim)) mag = lim;
    res = neg_q ? (32'd0 - mag) : mag;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.fit_clr) begin
      fit_q     <= 1'b0;
      coef_q[0] <= '0;
      coef_q[1] <= '0;
      coef_q[2] <= '0;
    end else begin
      if (cmd_i.fit_set) fit_q <= 1'b1;
      if (cmd_i.div_store) coef_q[cmd_i.dst[1:0]] <= res;
    end
    if (cmd_i.upd) fit_q <= 1'b0;
    if (cmd_i.out_load) begin
      out_q.fit_valid   <= fit_q;
      out_q.coef_a      <= coef_q[0];
      out_q.coef_b      <= coef_q[1];
      out_q.coef_c      <= coef_q[2];
      out_q.points_held <= cnt_q;
    end
  end

  assign sts_o.n_ok  = (cnt_q >= plsf_pkg::CNT_W'(plsf_pkg::MIN_POINTS));
  assign sts_o.zero  = (rda_q == '0) || (rdb_q == '0);
  assign out_item_o  = out_q;

endmodule

FILE: design/parabola_least_squares_fit.sv
`timescale 1ns / 1ps
// Least-squares parabola fit over running power sums; top level.
// Without three points the solve is skipped; when a denominator is zero it stops
// early. The solve runs on the bit-serial multiplier (one bit per cycle over 22
// products) and three 33-step restoring divisions. One item at a time; the next
// accept can come in the cycle after output load.
// Reset clears the point count, all sums and the output valid flag.
module parabola_least_squares_fit #(
  parameter int unsigned MAX_POINTS = 1024,
  parameter int unsigned X_BITS     = 12,
  parameter int unsigned Y_BITS     = 16,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  plsf_pkg::in_t  in_item_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output plsf_pkg::out_t out_item_o
);

  plsf_pkg::cmd_t cmd;
  plsf_pkg::sts_t sts;

  plsf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  plsf_dpath #(
    .MAX_POINTS (MAX_POINTS),
    .X_BITS     (X_BITS),
    .Y_BITS     (Y_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_item_i  (in_item_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_item_o (out_item_o)
  );

endmodule

FILE: tb/tb_parabola_least_squares_fit.sv
`timescale 1ns / 1ps
// Self-checking testbench for parabola_least_squares_fit: directed table, then random
// point sequences, checked against table values or an exact 256-bit predictor. Depends on plsf_pkg.
module tb_parabola_least_squares_fit;

  localparam logic [1:0] KIND_NOP = 2'd3;
  localparam int unsigned LIMIT_PTS = 1024;
  localparam int unsigned FRAC_W = 16;

  typedef logic signed [255:0] wide_t;

  typedef struct {
    plsf_pkg::in_t  item;
    bit             typed;
    plsf_pkg::out_t want;
  } row_t;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  plsf_pkg::in_t  in_item_i;
  logic out_valid_o;
  logic out_stall_i;
  plsf_pkg::out_t out_item_o;

  plsf_pkg::out_t fit_q[$];
  bit   failed;
  bit   quiet;
  int   stall_left;
  row_t rows[$];

  logic [10:0]        held;
  logic signed [22:0] sx;
  logic signed [32:0] sx2;
  logic signed [44:0] sx3;
  logic signed [54:0] sx4;
  logic signed [26:0] sy;
  logic signed [37:0] sxy;
  logic signed [48:0] sx2y;

  parabola_least_squares_fit DUT (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_item_i(in_item_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_item_o(out_item_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #200000000;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic logic [31:0] round_fix(wide_t num, wide_t den);
    logic         neg;
    logic [255:0] un;
    logic [255:0] ud;
    logic [255:0] q;
    logic [31:0]  lim;
    logic [31:0]  mag;
    neg = num[255] ^ den[255];
    un  = num[255] ? -num : num;
    ud  = den[255] ? -den : den;
    un  = un << FRAC_W;
    q   = ((un << 1) + ud) / (ud << 1);
    lim = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    mag = (q[255:32] != 0) ? lim : q[31:0];
    if (mag > lim) mag = lim;
    return neg ? -mag : mag;
  endfunction

  function automatic void clear_sums();
    held = '0; sx = '0; sx2 = '0; sx3 = '0; sx4 = '0; sy = '0; sxy = '0; sx2y = '0;
  endfunction

  function automatic plsf_pkg::out_t fit_step(plsf_pkg::in_t it);
    longint xv, yv, x2, sg;
    wide_t  n, s1, s2, s3, s4, t0, t1, t2;
    wide_t  a, b, c, e, f, nn, z, bn, bd, cn;
    plsf_pkg::out_t r;
    xv = longint'(it.x);
    yv = longint'(it.y);
    x2 = xv * xv;
    sg = 0;
    if (it.kind == plsf_pkg::KIND_ADD && held < LIMIT_PTS) begin
      held = held + 11'd1;
      sg = 1;
    end else if (it.kind == plsf_pkg::KIND_REM && held > 0) begin
      held = held - 11'd1;
      sg = -1;
    end else if (it.kind == plsf_pkg::KIND_CLR) begin
      clear_sums();
    end
    if (sg != 0) begin
      sx   = 23'(sx + sg * xv);
      sx2  = 33'(sx2 + sg * x2);
      sx3  = 45'(sx3 + sg * x2 * xv);
      sx4  = 55'(sx4 + sg * x2 * x2);
      sy   = 27'(sy + sg * yv);
      sxy  = 38'(sxy + sg * xv * yv);
      sx2y = 49'(sx2y + sg * x2 * yv);
    end
    r = '0;
    r.points_held = held;
    if (held >= plsf_pkg::MIN_POINTS) begin
      n  = {245'd0, held};
      s1 = 256'(sx); s2 = 256'(sx2); s3 = 256'(sx3); s4 = 256'(sx4);
      t0 = 256'(sy); t1 = 256'(sxy); t2 = 256'(sx2y);
      a  = n * s3 - s1 * s2;
      b  = n * s2 - s1 * s1;
      c  = n * s4 - s2 * s2;
      e  = n * t1 - t0 * s1;
      f  = n * t2 - t0 * s2;
      nn = b * c - a * a;
      if (b != 0 && nn != 0) begin
        z  = b * f - a * e;
        bn = e * nn - z * a;
        bd = b * nn;
        cn = t0 * bd - z * s2 * b - bn * s1;
        r.fit_valid = 1'b1;
        r.coef_a = round_fix(z, nn);
        r.coef_b = round_fix(bn, bd);
        r.coef_c = round_fix(cn, n * bd);
      end
    end
    return r;
  endfunction

  function automatic plsf_pkg::in_t mk(logic [1:0] k, int xv, int yv);
    plsf_pkg::in_t it;
    it.kind = k;
    it.x = xv[11:0];
    it.y = yv[15:0];
    return it;
  endfunction

  function automatic plsf_pkg::out_t res(bit v, int a, int n);
    plsf_pkg::out_t o;
    o = '0;
    o.fit_valid = v;
    o.coef_a = a;
    o.points_held = n[10:0];
    return o;
  endfunction

  task automatic send(plsf_pkg::in_t it, bit typed, plsf_pkg::out_t want);
    int   gap;
    plsf_pkg::out_t got;
    gap = 0;
    if (!quiet) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 60) : $urandom_range(0, 2);
    end
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i <= it;
    do @(posedge clk_i); while (in_stall_o);
    got = fit_step(it);
    fit_q.push_back(typed ? want : got);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (fit_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic add_rand(bit wide_pts);
    int xv, yv;
    if (wide_pts) begin
      xv = $urandom_range(0, 4095) - 2048;
      yv = $urandom_range(0, 65535) - 32768;
    end else begin
      xv = $urandom_range(0, 16) - 8;
      yv = $urandom_range(0, 400) - 200;
    end
    send(mk(plsf_pkg::KIND_ADD, xv, yv), 1'b0, '0);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else if (!quiet && $urandom_range(0, 3) == 0) begin
      out_stall_i <= 1'b1;
      stall_left <= ($urandom_range(0, 15) == 0) ? $urandom_range(20, 80)
                                                 : $urandom_range(0, 3);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    plsf_pkg::out_t w;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (fit_q.size() == 0) begin
        $display("%0t: unexpected item %p", $time, out_item_o);
        failed = 1'b1;
      end else begin
        w = fit_q.pop_front();
        if (out_item_o.fit_valid !== w.fit_valid) begin
          $display("%0t: fit_valid exp %0d got %0d", $time, w.fit_valid, out_item_o.fit_valid);
          failed = 1'b1;
        end
        if (out_item_o.coef_a !== w.coef_a) begin
          $display("%0t: coef_a exp %0d got %0d", $time, w.coef_a, out_item_o.coef_a);
          failed = 1'b1;
        end
        if (out_item_o.coef_b !== w.coef_b) begin
          $display("%0t: coef_b exp %0d got %0d", $time, w.coef_b, out_item_o.coef_b);
          failed = 1'b1;
        end
        if (out_item_o.coef_c !== w.coef_c) begin
          $display("%0t: coef_c exp %0d got %0d", $time, w.coef_c, out_item_o.coef_c);
          failed = 1'b1;
        end
        if (out_item_o.points_held !== w.points_held) begin
          $display("%0t: points_held exp %0d got %0d", $time, w.points_held,
                   out_item_o.points_held);
          failed = 1'b1;
        end
      end
    end
  end

  initial begin
    int sent, mode, len;
    failed = 1'b0;
    quiet = 1'b0;
    clear_sums();
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_item_i = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    rows.push_back('{mk(plsf_pkg::KIND_ADD, 0, 0), 1'b1, res(1'b0, 0, 1)});
    rows.push_back('{mk(plsf_pkg::KIND_ADD, 1, 1), 1'b1, res(1'b0, 0, 2)});
    rows.push_back('{mk(plsf_pkg::KIND_ADD, 2, 4), 1'b1, res(1'b1, 65536, 3)});
    rows.push_back('{mk(plsf_pkg::KIND_ADD, -2048, -32768), 1'b0, '0});
    rows.push_back('{mk(plsf_pkg::KIND_ADD, 2047, 32767), 1'b0, '0});
    rows.push_back('{mk(plsf_pkg::KIND_REM, 1, 1), 1'b0, '0});
    rows.push_back('{mk(KIND_NOP, -1, -1), 1'b0, '0});
    rows.push_back('{mk(plsf_pkg::KIND_CLR, 2047, -1), 1'b1, res(1'b0, 0, 0)});
    rows.push_back('{mk(plsf_pkg::KIND_REM, -2048, 32767), 1'b1, res(1'b0, 0, 0)});
    rows.push_back('{mk(plsf_pkg::KIND_ADD, 7, 3), 1'b1, res(1'b0, 0, 1)});
    rows.push_back('{mk(plsf_pkg::KIND_ADD, 7, -3), 1'b1, res(1'b0, 0, 2)});
    rows.push_back('{mk(plsf_pkg::KIND_ADD, 7, 100), 1'b1, res(1'b0, 0, 3)});
    rows.push_back('{mk(plsf_pkg::KIND_ADD, -1, 2), 1'b0, '0});
    rows.push_back('{mk(plsf_pkg::KIND_REM, 100, 100), 1'b0, '0});
    rows.push_back('{mk(plsf_pkg::KIND_ADD, 2047, -32768), 1'b0, '0});
    rows.push_back('{mk(plsf_pkg::KIND_CLR, 0, 0), 1'b1, res(1'b0, 0, 0)});
    foreach (rows[i]) send(rows[i].item, rows[i].typed, rows[i].want);
    drain();
    sent = rows.size();

    quiet = 1'b1;
    repeat (LIMIT_PTS + 6) begin
      mode = $urandom_range(0, 3);
      send(mk(plsf_pkg::KIND_ADD,
              mode == 0 ? 2047 : (mode == 1 ? -2048 : $urandom_range(0, 4095) - 2048),
              $urandom_range(0, 65535) - 32768), 1'b0, '0);
      sent++;
    end
    send(mk(plsf_pkg::KIND_REM, -2048, 32767), 1'b0, '0);
    send(mk(plsf_pkg::KIND_CLR, 0, 0), 1'b0, '0);
    sent += 2;
    quiet = 1'b0;

    while (sent < 1850) begin
      mode = $urandom_range(0, 99);
      if (mode < 75) begin
        len = $urandom_range(3, 12);
        send(mk(plsf_pkg::KIND_CLR, $urandom_range(0, 4095), $urandom_range(0, 65535)),
             1'b0, '0);
        repeat (len) add_rand(1'($urandom_range(0, 1)));
        if ($urandom_range(0, 2) == 0) begin
          send(mk(plsf_pkg::KIND_REM, $urandom_range(0, 16) - 8,
                  $urandom_range(0, 400) - 200), 1'b0, '0);
          sent++;
        end
        sent += len + 1;
      end else if (mode < 90) begin
        send(mk(plsf_pkg::KIND_REM, $urandom_range(0, 4095), $urandom_range(0, 65535)),
             1'b0, '0);
        sent++;
      end else if (mode < 95) begin
        send(mk(KIND_NOP, $urandom_range(0, 4095), $urandom_range(0, 65535)), 1'b0, '0);
        sent++;
      end else begin
        quiet = ($urandom_range(0, 1) == 0);
        add_rand(1'b1);
        sent++;
      end
    end
    quiet = 1'b0;
    drain();
    repeat (1100) @(posedge clk_i);
    if (!failed && fit_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
